>>> rtl/sfc_pkg.sv
// Shared types and constants for the signature file carver.
`default_nettype none
package sfc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OFFS_W    = 32;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned PAT_W     = 64;
  localparam int unsigned LENS_W    = 24;
  localparam int unsigned FTR_LEN_LSB = 12;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OUT_TDATA_W = 72;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FTR_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS  = 3'd6;

  typedef struct packed {
    logic [OFFS_W-1:0] start;
    logic [OFFS_W-1:0] stop;
    logic [KIND_W-1:0] kind;
  } rec_t;

  typedef struct packed {
    logic              active;
    logic [OFFS_W-1:0] start;
    logic [KIND_W-1:0] kind;
  } open_t;

endpackage
`default_nettype wire

>>> rtl/sfc_match.sv
// Compares the leading bytes of the window against one pattern.
`default_nettype none
module sfc_match #(
  parameter int unsigned WINDOW = 8
) (
  input  logic [WINDOW-1:0][sfc_pkg::BYTE_W-1:0] win_i,
  input  logic [sfc_pkg::PAT_W-1:0]              pat_i,
  input  logic [sfc_pkg::LEN_W-1:0]              len_i,
  output logic                                   hit_o
);

  logic same;

  always_comb begin
    same = 1'b1;
    for (int k = 0; k < WINDOW; k++) begin
      if ((sfc_pkg::LEN_W'(k) < len_i) && (win_i[k] != pat_i[k*8 +: 8])) begin
        same = 1'b0;
      end
    end
    // zero length disables; lengths past the window never match
    hit_o = same && (len_i != '0) && (32'(len_i) <= WINDOW);
  end

endmodule
`default_nettype wire

>>> rtl/sfc_chain.sv
// Walks the signatures in order for one byte and builds its records.
`default_nettype none
module sfc_chain #(
  parameter int unsigned SIGNATURES = 3,
  parameter int unsigned CNT_W      = 2
) (
  input  sfc_pkg::open_t                         open_i,
  input  logic                                   stream_end_i,
  input  logic                                   test_i,
  input  logic [sfc_pkg::OFFS_W-1:0]             pos_i,
  input  logic [sfc_pkg::OFFS_W-1:0]             seen_i,
  input  logic [SIGNATURES-1:0]                  hdr_hit_i,
  input  logic [SIGNATURES-1:0]                  ftr_hit_i,
  input  logic [SIGNATURES-1:0][sfc_pkg::LEN_W-1:0] ftr_len_i,
  output sfc_pkg::open_t                         open_o,
  output sfc_pkg::rec_t [SIGNATURES-1:0]         recs_o,
  output logic [CNT_W-1:0]                       cnt_o
);

  logic [sfc_pkg::OFFS_W:0]   fend_wide;
  logic [sfc_pkg::OFFS_W-1:0] fend;
  sfc_pkg::rec_t              rec;

  always_comb begin
    open_o    = open_i;
    recs_o    = '0;
    cnt_o     = '0;
    fend_wide = '0;
    fend      = '0;
    rec       = '0;
    if (stream_end_i) begin
      if (open_i.active) begin
        recs_o[0].start = open_i.start;
        recs_o[0].stop  = seen_i;
        recs_o[0].kind  = open_i.kind;
        cnt_o           = CNT_W'(1);
      end
      open_o = '0;
    end else if (test_i) begin
      for (int i = 0; i < SIGNATURES; i++) begin
        fend_wide = {1'b0, pos_i} + (sfc_pkg::OFFS_W + 1)'(ftr_len_i[i]);
        fend = fend_wide[sfc_pkg::OFFS_W] ? '1 : fend_wide[sfc_pkg::OFFS_W-1:0];
        rec.start = open_o.start;
        rec.kind  = open_o.kind;
        rec.stop  = hdr_hit_i[i] ? pos_i : fend;
        if (hdr_hit_i[i]) begin
          if (open_o.active) begin
            for (int j = 0; j < SIGNATURES; j++) begin
              if (CNT_W'(j) == cnt_o) recs_o[j] = rec;
            end
            cnt_o = cnt_o + CNT_W'(1);
          end
          open_o.active = 1'b1;
          open_o.start  = pos_i;
          open_o.kind   = sfc_pkg::KIND_W'(i);
        end else if (open_o.active && ftr_hit_i[i]) begin
          for (int j = 0; j < SIGNATURES; j++) begin
            if (CNT_W'(j) == cnt_o) recs_o[j] = rec;
          end
          cnt_o         = cnt_o + CNT_W'(1);
          open_o.active = 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/sfc_outbuf.sv
// Holds the records of one byte and hands them out one word at a time.
`default_nettype none
module sfc_outbuf #(
  parameter int unsigned DEPTH = 3,
  parameter int unsigned CNT_W = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  sfc_pkg::rec_t [DEPTH-1:0]      recs_i,
  input  logic [CNT_W-1:0]               cnt_i,
  input  logic                           pop_i,
  output logic                           valid_o,
  output logic                           last_o,
  output logic                           space_o,
  output sfc_pkg::rec_t                  head_o
);

  sfc_pkg::rec_t [DEPTH-1:0] slot_q;
  logic [CNT_W-1:0]          cnt_q;

  assign valid_o = (cnt_q != '0);
  assign last_o  = (cnt_q == CNT_W'(1));
  assign head_o  = slot_q[0];
  // room for a new byte once at most the final record is leaving
  assign space_o = (cnt_q == '0) || (last_o && pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= cnt_i;
    end else if (pop_i && valid_o) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= recs_i;
    end else if (pop_i && valid_o) begin
      for (int j = 0; j < DEPTH - 1; j++) begin
        slot_q[j] <= slot_q[j+1];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/signature_file_carver.sv
// Top level of the signature file carver.
// Scans a byte stream one byte per cycle over a sliding window and reports
// carved records (start, one-past-end, signature kind). An input word is
// taken every cycle while the output drains; a byte that yields several records
// (up to SIGNATURES) holds the input until its last record leaves, since the single
// output port moves one record per cycle. A stream-end word (tuser set)
// flushes an open record and clears the window and the byte counter.
// Configuration writes are taken at any time and must land while idle.
`default_nettype none
module signature_file_carver #(
  parameter int unsigned WINDOW     = 8,
  parameter int unsigned SIGNATURES = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] stream_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [31:0] record_start, [63:32] record_end,
                                      // [65:64] record_kind, rest zero
  output logic        m_axis_tlast,   // run_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(SIGNATURES + 1);

  logic [SIGNATURES-1:0][sfc_pkg::PAT_W-1:0] hdr_q, ftr_q;
  logic [sfc_pkg::LENS_W-1:0]                lens_q;

  logic [WINDOW-1:0][sfc_pkg::BYTE_W-1:0] win_q, win_d;
  logic [sfc_pkg::OFFS_W-1:0]             seen_q, seen_d, pos;
  sfc_pkg::open_t                         open_q, open_d;

  logic                                      accept, test;
  logic [SIGNATURES-1:0]                     hdr_hit, ftr_hit;
  logic [SIGNATURES-1:0][sfc_pkg::LEN_W-1:0] hdr_len, ftr_len;
  sfc_pkg::rec_t [SIGNATURES-1:0]            recs;
  logic [CNT_W-1:0]                          rec_cnt;
  sfc_pkg::rec_t                             head;
  logic                                      space;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q  <= '0;
      ftr_q  <= '0;
      lens_q <= '0;
    end else if (cfg_valid_i) begin
      for (int i = 0; i < SIGNATURES; i++) begin
        if (cfg_index_i == sfc_pkg::CFG_HDR_BASE + sfc_pkg::CFG_IDX_W'(i)) hdr_q[i] <= cfg_data_i;
        if (cfg_index_i == sfc_pkg::CFG_FTR_BASE + sfc_pkg::CFG_IDX_W'(i)) ftr_q[i] <= cfg_data_i;
      end
      if (cfg_index_i == sfc_pkg::CFG_LENGTHS) lens_q <= cfg_data_i[sfc_pkg::LENS_W-1:0];
    end
  end

  // window, counter and match
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    win_d[WINDOW-2:0] = win_q[WINDOW-1:1];
    win_d[WINDOW-1]   = s_axis_tdata;
    seen_d = (seen_q == '1) ? seen_q : seen_q + sfc_pkg::OFFS_W'(1);
    test   = (seen_d >= sfc_pkg::OFFS_W'(WINDOW));
    pos    = seen_d - sfc_pkg::OFFS_W'(WINDOW);
  end

  for (genvar g = 0; g < SIGNATURES; g++) begin : g_sig
    assign hdr_len[g] = lens_q[g*sfc_pkg::LEN_W +: sfc_pkg::LEN_W];
    assign ftr_len[g] = lens_q[sfc_pkg::FTR_LEN_LSB + g*sfc_pkg::LEN_W +: sfc_pkg::LEN_W];

    sfc_match #(.WINDOW(WINDOW)) u_hdr (
      .win_i(win_d), .pat_i(hdr_q[g]), .len_i(hdr_len[g]), .hit_o(hdr_hit[g])
    );
    sfc_match #(.WINDOW(WINDOW)) u_ftr (
      .win_i(win_d), .pat_i(ftr_q[g]), .len_i(ftr_len[g]), .hit_o(ftr_hit[g])
    );
  end

  sfc_chain #(.SIGNATURES(SIGNATURES), .CNT_W(CNT_W)) u_chain (
    .open_i      (open_q),
    .stream_end_i(s_axis_tuser),
    .test_i      (test),
    .pos_i       (pos),
    .seen_i      (seen_q),
    .hdr_hit_i   (hdr_hit),
    .ftr_hit_i   (ftr_hit),
    .ftr_len_i   (ftr_len),
    .open_o      (open_d),
    .recs_o      (recs),
    .cnt_o       (rec_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      seen_q <= '0;
      open_q <= '0;
    end else if (accept) begin
      open_q <= open_d;
      if (s_axis_tuser) begin
        win_q  <= '0;
        seen_q <= '0;
      end else begin
        win_q  <= win_d;
        seen_q <= seen_d;
      end
    end
  end

  // result queue
  sfc_outbuf #(.DEPTH(SIGNATURES), .CNT_W(CNT_W)) u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .recs_i (recs),
    .cnt_i  (rec_cnt),
    .pop_i  (m_axis_tready),
    .valid_o(m_axis_tvalid),
    .last_o (m_axis_tlast),
    .space_o(space),
    .head_o (head)
  );

  assign s_axis_tready = space;
  assign m_axis_tdata  = {6'b0, head.kind, head.stop, head.start};

  // checks
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser |=> (seen_q == '0) && !open_q.active)
    else $error("stream end did not clear the scan state");

  a_seen_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !s_axis_tuser |=> seen_q >= $past(seen_q))
    else $error("byte counter went backward");

  a_rec_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> head.start <= head.stop)
    else $error("record ends before it starts");

endmodule
`default_nettype wire

>>> tb/sv/signature_file_carver_checker.sv
// Checker for the signature file carver: predicts carved records and compares them.
module signature_file_carver_checker
  import sfc_pkg::*;
#(
  parameter int unsigned WINDOW     = 8,
  parameter int unsigned SIGNATURES = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] data_byte
  input  logic                   s_axis_tuser,   // [0] stream_end
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] start, [63:32] end, [65:64] kind
  input  logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [PAT_W-1:0]       cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    rec_t span;
    logic last;
  } carved_t;

  logic [PAT_W-1:0]  hdr_pat [3];
  logic [PAT_W-1:0]  ftr_pat [3];
  logic [LENS_W-1:0] lens;
  logic [BYTE_W-1:0] win [8];      // oldest byte at index 0
  logic [OFFS_W-1:0] seen;
  open_t             open_rec;
  carved_t           records_due [$];
  int                fails = 0;

  function automatic carved_t make_rec(input logic [OFFS_W-1:0] start,
                                       input logic [OFFS_W-1:0] stop,
                                       input logic [KIND_W-1:0] kind);
    carved_t r;
    r.span.start = start;
    r.span.stop  = stop;
    r.span.kind  = kind;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic window_holds(input logic [PAT_W-1:0] pat,
                                        input logic [LEN_W-1:0] len);
    logic hit;
    hit = (len != 0) && (len <= WINDOW) && (len <= 8);
    for (int k = 0; k < 8; k++)
      if (k < len && win[k] != pat[8*k +: 8]) hit = 1'b0;
    return hit;
  endfunction

  task automatic clear_stream();
    for (int k = 0; k < 8; k++) win[k] = '0;
    seen     = '0;
    open_rec = '0;
  endtask

  task automatic store_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [PAT_W-1:0] data);
    if (idx < CFG_FTR_BASE) hdr_pat[idx - CFG_HDR_BASE] = data;
    else if (idx < CFG_LENGTHS) ftr_pat[idx - CFG_FTR_BASE] = data;
    else if (idx == CFG_LENGTHS) lens = data[LENS_W-1:0];
  endtask

  // Records caused by one stream word, in the order the block must emit them.
  task automatic predict_word(input logic [BYTE_W-1:0] b, input logic fin);
    carved_t           batch [$];
    logic [OFFS_W-1:0] pos;
    logic [OFFS_W:0]   stop_wide;
    logic [LEN_W-1:0]  hl;
    logic [LEN_W-1:0]  fl;
    if (fin) begin
      if (open_rec.active) batch = {batch, make_rec(open_rec.start, seen, open_rec.kind)};
      clear_stream();
    end else begin
      for (int k = 0; k < WINDOW - 1; k++) win[k] = win[k+1];
      win[WINDOW-1] = b;
      if (seen != {OFFS_W{1'b1}}) seen = seen + 1'b1;
      if (seen >= WINDOW) begin
        pos = seen - WINDOW;
        for (int i = 0; i < SIGNATURES && i < 3; i++) begin
          hl = lens[LEN_W*i +: LEN_W];
          fl = lens[FTR_LEN_LSB + LEN_W*i +: LEN_W];
          if (window_holds(hdr_pat[i], hl)) begin
            if (open_rec.active)
              batch = {batch, make_rec(open_rec.start, pos, open_rec.kind)};
            open_rec.active = 1'b1;
            open_rec.start  = pos;
            open_rec.kind   = KIND_W'(i);
          end else if (open_rec.active && window_holds(ftr_pat[i], fl)) begin
            // footer end saturates at the top of the offset range
            stop_wide = {1'b0, pos} + fl;
            batch = {batch, make_rec(open_rec.start,
                                     stop_wide[OFFS_W] ? {OFFS_W{1'b1}} :
                                                         stop_wide[OFFS_W-1:0],
                                     open_rec.kind)};
            open_rec.active = 1'b0;
          end
        end
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    records_due = {records_due, batch};
  endtask

  task automatic check_record(input logic [OUT_TDATA_W-1:0] data, input logic last);
    carved_t want;
    rec_t    got;
    got.start = data[OFFS_W-1:0];
    got.stop  = data[2*OFFS_W-1:OFFS_W];
    got.kind  = data[2*OFFS_W +: KIND_W];
    if (records_due.size() == 0) begin
      fails++;
      if (fails <= REPORT_MAX)
        $display("carver: record with none due: start=%0d end=%0d kind=%0d last=%0b",
                 got.start, got.stop, got.kind, last);
    end else begin
      want = records_due.pop_front();
      if (got.start != want.span.start || got.stop != want.span.stop ||
          got.kind != want.span.kind || last != want.last) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("carver: record mismatch: expected start=%0d end=%0d kind=%0d last=%0b,",
                   want.span.start, want.span.stop, want.span.kind, want.last,
                   " got start=%0d end=%0d kind=%0d last=%0b",
                   got.start, got.stop, got.kind, last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        hdr_pat[i] = '0;
        ftr_pat[i] = '0;
      end
      lens = '0;
      clear_stream();
      records_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) store_register(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) predict_word(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) check_record(m_axis_tdata, m_axis_tlast);
    end
    fail_count_o = fails;
    pending_o    = records_due.size();
  end

endmodule

>>> tb/sv/signature_file_carver_tb.sv
// Testbench top for the signature file carver: byte stream and register stimulus, verdict.
module signature_file_carver_tb;
  import sfc_pkg::*;

  localparam int unsigned WINDOW      = 8;
  localparam int unsigned SIGS        = 3;
  localparam int          IDLE_PCT    = 21;
  localparam int          PHASE_WORDS = 75;
  localparam int          SETTLE      = 16;
  localparam int          STALL_LIMIT = 4000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_LENGTHS + 3'd1;

  typedef enum int {MIX_DENSE, MIX_FULL, MIX_NEVER, MIX_ANY} mix_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [BYTE_W-1:0]      s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [PAT_W-1:0]       cfg_data_i    = '0;
  int                     fail_count;
  int                     pending;

  logic             steady = 1'b0;   // no idling on either side while set
  int               words_sent = 0;
  int               stall_cycles = 0;
  logic [PAT_W-1:0] hdr_pat [3];
  logic [PAT_W-1:0] ftr_pat [3];
  logic [LEN_W-1:0] hdr_len [3];
  logic [LEN_W-1:0] ftr_len [3];
  mix_e             plan [6] = '{MIX_DENSE, MIX_FULL, MIX_NEVER, MIX_ANY, MIX_DENSE, MIX_ANY};

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  signature_file_carver #(.WINDOW(WINDOW), .SIGNATURES(SIGS)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  signature_file_carver_checker #(.WINDOW(WINDOW), .SIGNATURES(SIGS)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(negedge clk_i) m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Returns right after the accepting edge; valid stays up for the next word.
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic fin);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_pattern(input logic [PAT_W-1:0] pat, input int n);
    for (int k = 0; k < n && k < 8; k++) send_word(pat[8*k +: 8], 1'b0);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Junk above bit 23 of the length word must be dropped by the block.
  task automatic apply_config();
    logic [LENS_W-1:0] lens;
    for (int i = 0; i < 3; i++) begin
      lens[LEN_W*i +: LEN_W]               = hdr_len[i];
      lens[FTR_LEN_LSB + LEN_W*i +: LEN_W] = ftr_len[i];
      write_reg(CFG_HDR_BASE + CFG_IDX_W'(i), hdr_pat[i]);
      write_reg(CFG_FTR_BASE + CFG_IDX_W'(i), ftr_pat[i]);
    end
    write_reg(CFG_LENGTHS, {$urandom, 8'($urandom), lens});
  endtask

  function automatic logic [BYTE_W-1:0] dense_byte();
    logic [BYTE_W-1:0] b;
    case ($urandom_range(3))
      0:       b = 8'h00;
      1:       b = 8'hFF;
      2:       b = 8'h5A;
      default: b = 8'hA5;
    endcase
    return b;
  endfunction

  // Filler that often repeats pattern bytes, so near-misses and overlaps show up.
  function automatic logic [BYTE_W-1:0] stray_byte();
    logic [PAT_W-1:0] p;
    int               pick;
    pick = $urandom_range(5);
    p    = (pick < 3) ? hdr_pat[pick] : ftr_pat[pick - 3];
    if ($urandom_range(1) == 0) return 8'($urandom);
    return p[8*$urandom_range(7) +: 8];
  endfunction

  task automatic load_config(input mix_e mix);
    for (int i = 0; i < 3; i++) begin
      case (mix)
        MIX_DENSE: begin
          hdr_len[i] = LEN_W'($urandom_range(4, 1));
          ftr_len[i] = LEN_W'($urandom_range(4, 1));
          for (int k = 0; k < 8; k++) begin
            hdr_pat[i][8*k +: 8] = dense_byte();
            ftr_pat[i][8*k +: 8] = dense_byte();
          end
        end
        MIX_FULL: begin
          hdr_len[i] = LEN_W'(8);
          ftr_len[i] = LEN_W'(8);
          hdr_pat[i] = {$urandom, $urandom};
          ftr_pat[i] = {$urandom, $urandom};
        end
        MIX_NEVER: begin
          // lengths past the window, up to the largest code
          hdr_len[i] = LEN_W'(9 + 3*i);
          ftr_len[i] = '1;
          hdr_pat[i] = '1;
          ftr_pat[i] = '1;
        end
        default: begin
          hdr_len[i] = LEN_W'($urandom_range(15));
          ftr_len[i] = LEN_W'($urandom_range(15));
          hdr_pat[i] = {$urandom, $urandom};
          ftr_pat[i] = {$urandom, $urandom};
        end
      endcase
    end
    apply_config();
  endtask

  // Mostly header .. filler .. footer runs, with some noise, cut headers and stream ends.
  task automatic random_phase(input int words);
    int first;
    int sig;
    first = words_sent;
    while (words_sent - first < words) begin
      sig = $urandom_range(SIGS - 1);
      case ($urandom_range(19))
        0:       send_word(8'($urandom), 1'b1);
        1, 2:    repeat ($urandom_range(6, 1)) send_word(8'($urandom), 1'b0);
        3:       send_pattern(hdr_pat[sig], $urandom_range(hdr_len[sig]));
        default: begin
          send_pattern(hdr_pat[sig], hdr_len[sig]);
          repeat ($urandom_range(10)) send_word(stray_byte(), 1'b0);
          send_pattern(ftr_pat[sig], ftr_len[sig]);
          repeat ($urandom_range(4)) send_word(stray_byte(), 1'b0);
        end
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      hdr_pat[i] = '0;
      ftr_pat[i] = '0;
      hdr_len[i] = '0;
      ftr_len[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: zero patterns with zero lengths must not match a zero window
    send_pattern('0, 8);
    send_word(8'($urandom), 1'b1);
    drain();

    hdr_pat[0] = 64'h0000_0000_474E_5089;
    ftr_pat[0] = 64'h0000_0000_8260_42AE;
    hdr_pat[1] = '1;
    ftr_pat[1] = '0;
    hdr_pat[2] = {$urandom, $urandom};
    ftr_pat[2] = {$urandom, $urandom};
    hdr_len    = '{LEN_W'(4), LEN_W'(8), LEN_W'(9)};
    ftr_len    = '{LEN_W'(4), LEN_W'(1), LEN_W'(15)};
    apply_config();
    write_reg(CFG_SPARE, {$urandom, $urandom});

    // header bytes too early to fill the window, then a flush
    send_pattern(hdr_pat[0], 3);
    send_word(8'($urandom), 1'b1);
    // header 0, its footer, then a full-window header 1 left open for the flush
    send_pattern(64'h8260_42AE_474E_5089, 8);
    send_pattern('1, 8);
    send_word(8'($urandom), 1'b1);

    for (int p = 0; p < 6; p++) begin
      drain();
      load_config(plan[p]);
      steady = (p == 1);
      if (p == 0) begin
        random_phase(PHASE_WORDS / 2);
        drain();
        random_phase(PHASE_WORDS - PHASE_WORDS / 2);
      end else begin
        random_phase(PHASE_WORDS);
      end
    end
    steady = 1'b0;

    stop_sending();
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> signature_file_carver.f
rtl/sfc_pkg.sv
rtl/sfc_match.sv
rtl/sfc_chain.sv
rtl/sfc_outbuf.sv
rtl/signature_file_carver.sv
tb/sv/signature_file_carver_checker.sv
tb/sv/signature_file_carver_tb.sv
